[rtl/ilst_pkg.sv]
// Shared constants, codes, types and word helpers for the indexed shift list.
`timescale 1ns / 1ps

package ilst_pkg;

  // List geometry
  localparam int CAPACITY   = 16;
  localparam int WORD_WIDTH = 32;

  // Field widths of the stream items
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Derived widths
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_READ   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Storage access issued by the sequencer
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [WORD_WIDTH-1:0] wdata;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

  // One result item
  typedef struct packed {
    logic                  is_empty;
    status_t               status;
    logic [COUNT_W-1:0]    count;
    logic [VALUE_W-1:0]    read_data;
  } res_t;

  // Cut a signed input value to the stored word width
  function automatic logic [WORD_WIDTH-1:0] to_word(input logic [VALUE_W-1:0] v);
    logic [63:0] ext;
    ext = {{(64 - VALUE_W){v[VALUE_W-1]}}, v};
    return ext[WORD_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word back to the value width
  function automatic logic [VALUE_W-1:0] from_word(input logic [WORD_WIDTH-1:0] w);
    logic signed [63:0] ext;
    ext = 64'($signed(w));
    return ext[VALUE_W-1:0];
  endfunction

endpackage

[rtl/ilst_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ilst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ilst_ctrl.sv]
// Command sequencer with the shared index step unit that shifts entries one at a time.
`timescale 1ns / 1ps

module ilst_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ilst_pkg::CMD_W-1:0]          in_cmd,
  input  logic [ilst_pkg::POS_W-1:0]          in_pos,
  input  logic [ilst_pkg::VALUE_W-1:0]        in_value,
  output ilst_pkg::ram_req_t                  ram_req,
  input  logic [ilst_pkg::WORD_WIDTH-1:0]     ram_rdata,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ilst_pkg::res_t                      res
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_EXEC     = 6'b000010,
    S_SHIFT_RD = 6'b000100,
    S_SHIFT_WR = 6'b001000,
    S_READ     = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  localparam logic [ilst_pkg::CNT_W-1:0] CAP = ilst_pkg::CNT_W'(ilst_pkg::CAPACITY);

  state_t                            state, state_next;
  ilst_pkg::cmd_t                    cmd_r;
  logic [ilst_pkg::CMP_W-1:0]        pos_r;
  logic [ilst_pkg::WORD_WIDTH-1:0]   word_r;
  logic [ilst_pkg::CNT_W-1:0]        length, length_next;
  logic [ilst_pkg::CNT_W-1:0]        idx, idx_next;
  logic [ilst_pkg::VALUE_W-1:0]      rd, rd_next;
  ilst_pkg::status_t                 status, status_next;

  logic                              ins;
  logic [ilst_pkg::CNT_W-1:0]        adj;
  logic [ilst_pkg::CMP_W-1:0]        len_c;
  logic [ilst_pkg::CMP_W-1:0]        idx_c;
  logic                              more;

  // Shared step unit: one index adder and the loop test
  assign ins   = (cmd_r == ilst_pkg::CMD_INSERT);
  assign adj   = ins ? (idx - 1'b1) : (idx + 1'b1);
  assign len_c = ilst_pkg::CMP_W'(length);
  assign idx_c = ilst_pkg::CMP_W'(idx);
  assign more  = ins ? (idx_c > pos_r) : (adj < length);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.read_data = rd;
    res.count     = ilst_pkg::COUNT_W'(length);
    res.status    = status;
    res.is_empty  = (length == '0);
  end

  // Sequence the command
  always_comb begin
    state_next    = state;
    length_next   = length;
    idx_next      = idx;
    rd_next       = rd;
    status_next   = status;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx[ilst_pkg::IDX_W-1:0];
    ram_req.wdata = word_r;
    ram_req.raddr = adj[ilst_pkg::IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next  = S_EXEC;
          rd_next     = '0;
          status_next = ilst_pkg::STAT_OK;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (cmd_r)
          ilst_pkg::CMD_APPEND: begin
            if (length >= CAP) begin
              status_next = ilst_pkg::STAT_FULL;
            end else begin
              ram_req.we    = 1'b1;
              ram_req.waddr = length[ilst_pkg::IDX_W-1:0];
              length_next   = length + 1'b1;
            end
          end
          ilst_pkg::CMD_REMOVE: begin
            if (length != '0) begin
              length_next = length - 1'b1;
            end
          end
          ilst_pkg::CMD_INSERT: begin
            if (pos_r > len_c) begin
              status_next = ilst_pkg::STAT_RANGE;
            end else if (length >= CAP) begin
              status_next = ilst_pkg::STAT_FULL;
            end else begin
              idx_next   = length;
              state_next = S_SHIFT_RD;
            end
          end
          ilst_pkg::CMD_ERASE: begin
            if (pos_r >= len_c) begin
              status_next = ilst_pkg::STAT_RANGE;
            end else begin
              idx_next   = ilst_pkg::CNT_W'(pos_r);
              state_next = S_SHIFT_RD;
            end
          end
          ilst_pkg::CMD_CLEAR: begin
            length_next = '0;
          end
          ilst_pkg::CMD_READ: begin
            if (pos_r >= len_c) begin
              status_next = ilst_pkg::STAT_RANGE;
            end else begin
              ram_req.raddr = pos_r[ilst_pkg::IDX_W-1:0];
              state_next    = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      S_SHIFT_RD: begin
        // Fetch the neighbor, or finish the insert or erase
        if (more) begin
          state_next = S_SHIFT_WR;
        end else begin
          state_next = S_DONE;
          if (ins) begin
            ram_req.we  = 1'b1;
            length_next = length + 1'b1;
          end else begin
            length_next = length - 1'b1;
          end
        end
      end
      S_SHIFT_WR: begin
        // Move the fetched entry into the slot and advance
        ram_req.we    = 1'b1;
        ram_req.wdata = ram_rdata;
        idx_next      = adj;
        state_next    = S_SHIFT_RD;
      end
      S_READ: begin
        rd_next    = ilst_pkg::from_word(ram_rdata);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
    end else begin
      state  <= state_next;
      length <= length_next;
    end
  end

  // Command and working registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cmd_r  <= ilst_pkg::cmd_t'(in_cmd);
      pos_r  <= ilst_pkg::CMP_W'(in_pos);
      word_r <= ilst_pkg::to_word(in_value);
    end
    idx    <= idx_next;
    rd     <= rd_next;
    status <= status_next;
  end

endmodule

[rtl/indexed_shift_list.sv]
// An accepted command runs in S_EXEC; a read then fetches its word in S_READ, while insert
//   and erase shift count - position and count - position - 1 entries, with count taken
//   before the command, each in S_SHIFT_RD then S_SHIFT_WR; results wait in S_DONE.
// Each shift moves one entry through the single storage read and write port.
// Intake: one item at a time; the next item is accepted the cycle after the result moves
//   into the output register, which holds it until taken.
// Reset (rst, synchronous, active high) empties the list; stored words are not cleared.
`timescale 1ns / 1ps

module indexed_shift_list (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd[2:0], position[7:3], value[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // read_data[31:0], count[36:32], status[38:37], is_empty[39]
);

  ilst_pkg::ram_req_t                ram_req;
  logic [ilst_pkg::WORD_WIDTH-1:0]   ram_rdata;
  logic                              res_valid;
  logic                              res_ready;
  ilst_pkg::res_t                    res;
  ilst_pkg::res_t                    out_res;

  ilst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tdata[2:0]),
    .in_pos    (s_tdata[7:3]),
    .in_value  (s_tdata[39:8]),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ilst_ram #(
    .WIDTH (ilst_pkg::WORD_WIDTH),
    .DEPTH (ilst_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // Load the output register whenever it is free or being emptied
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = out_res;

  // A full report only comes from a list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.status == ilst_pkg::STAT_FULL)
      |-> (out_res.count == ilst_pkg::COUNT_W'(ilst_pkg::CAPACITY)))
    else $error("full status with list below capacity");

  // Read data is nonzero only on a successful command
  a_rd_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.read_data != '0) |-> (out_res.status == ilst_pkg::STAT_OK))
    else $error("read data returned with an error status");

  // An accepted item blocks intake until its result is done
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("intake open while an item is in work");

  // The output register is only reloaded after it was taken or empty
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result overwritten before being taken");

endmodule

[bench/tb_indexed_shift_list.sv]
// Self-checking testbench for the indexed shift list: directed and random commands.
`timescale 1ns / 1ps

module tb_indexed_shift_list;

  // Command codes outside the defined set; the list must treat them as no-ops
  localparam logic [ilst_pkg::CMD_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [ilst_pkg::CMD_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int PHASE_ITEMS = 104;
  localparam int DRAIN_CYCLES = 60;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // cmd[2:0], position[7:3], value[39:8]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // read_data[31:0], count[36:32], status[38:37], is_empty[39]

  int send_idle_pct;
  int sink_stall_pct;

  // Shadow of the list contents plus the queue of results still to arrive
  class list_scoreboard;
    logic [ilst_pkg::WORD_WIDTH-1:0] cells [ilst_pkg::CAPACITY];
    int unsigned                     fill_len;
    ilst_pkg::res_t                  pending_results [$];
    int                              errors;

    function new();
      fill_len = 0;
      errors   = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    // Apply one command to the shadow list and return the result it produces
    function ilst_pkg::res_t apply_command(logic [ilst_pkg::CMD_W-1:0] op,
                                           logic [ilst_pkg::POS_W-1:0] pos,
                                           logic [ilst_pkg::VALUE_W-1:0] val);
      ilst_pkg::res_t                  r;
      logic [ilst_pkg::WORD_WIDTH-1:0] w;
      logic signed [63:0]              wide;
      int unsigned                     p;
      r        = '0;
      r.status = ilst_pkg::STAT_OK;
      w        = val[ilst_pkg::WORD_WIDTH-1:0];
      p        = 32'(pos);
      case (op)
        ilst_pkg::CMD_APPEND: begin
          if (fill_len >= ilst_pkg::CAPACITY) begin
            r.status = ilst_pkg::STAT_FULL;
          end else begin
            cells[fill_len] = w;
            fill_len++;
          end
        end
        ilst_pkg::CMD_REMOVE: begin
          if (fill_len > 0) fill_len--;
        end
        ilst_pkg::CMD_INSERT: begin
          // range check wins over the full check
          if (p > fill_len) begin
            r.status = ilst_pkg::STAT_RANGE;
          end else if (fill_len >= ilst_pkg::CAPACITY) begin
            r.status = ilst_pkg::STAT_FULL;
          end else begin
            for (int i = fill_len; i > p; i--) cells[i] = cells[i-1];
            cells[p] = w;
            fill_len++;
          end
        end
        ilst_pkg::CMD_ERASE: begin
          if (p >= fill_len) begin
            r.status = ilst_pkg::STAT_RANGE;
          end else begin
            for (int i = p; i + 1 < fill_len; i++) cells[i] = cells[i+1];
            fill_len--;
          end
        end
        ilst_pkg::CMD_CLEAR: begin
          fill_len = 0;
        end
        ilst_pkg::CMD_READ: begin
          if (p >= fill_len) begin
            r.status = ilst_pkg::STAT_RANGE;
          end else begin
            wide        = 64'($signed(cells[p]));
            r.read_data = wide[ilst_pkg::VALUE_W-1:0];
          end
        end
        default: ;
      endcase
      r.count    = ilst_pkg::COUNT_W'(fill_len);
      r.is_empty = (fill_len == 0);
      return r;
    endfunction

    function void note_command(logic [39:0] item);
      pending_results = {pending_results, apply_command(item[2:0], item[7:3], item[39:8])};
    endfunction

    task check_result(logic [39:0] item);
      ilst_pkg::res_t got;
      ilst_pkg::res_t want;
      got = ilst_pkg::res_t'(item);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", item));
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
        if (got.count !== want.count)
          report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
      end
    endtask
  endclass

  list_scoreboard lists;

  indexed_shift_list uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stall the result side at random
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Record accepted commands and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) lists.note_command(s_tdata);
      if (m_tvalid && m_tready) lists.check_result(m_tdata);
    end
  end

  // Offer one item; entered and left at a falling edge
  task automatic send_item(input logic [ilst_pkg::CMD_W-1:0] op,
                           input logic [ilst_pkg::POS_W-1:0] pos,
                           input logic [ilst_pkg::VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ilst_pkg::VALUE_W-1:0] pick_value();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return 32'h0;
      endcase
    end
    return $urandom;
  endfunction

  // Random commands, in runs of 16 that each randomly favor growing or shrinking the list
  task automatic run_random(input int n);
    bit                         grow;
    int                         roll;
    int unsigned                len;
    logic [ilst_pkg::CMD_W-1:0] op;
    logic [ilst_pkg::POS_W-1:0] pos;
    for (int k = 0; k < n; k++) begin
      if (k % 16 == 0) grow = 1'($urandom_range(1));
      roll = $urandom_range(99);
      if (grow) begin
        if (roll < 35)      op = ilst_pkg::CMD_APPEND;
        else if (roll < 60) op = ilst_pkg::CMD_INSERT;
        else if (roll < 70) op = ilst_pkg::CMD_ERASE;
        else if (roll < 75) op = ilst_pkg::CMD_REMOVE;
        else if (roll < 95) op = ilst_pkg::CMD_READ;
        else if (roll < 97) op = ilst_pkg::CMD_CLEAR;
        else                op = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
      end else begin
        if (roll < 10)      op = ilst_pkg::CMD_APPEND;
        else if (roll < 20) op = ilst_pkg::CMD_INSERT;
        else if (roll < 50) op = ilst_pkg::CMD_ERASE;
        else if (roll < 70) op = ilst_pkg::CMD_REMOVE;
        else if (roll < 95) op = ilst_pkg::CMD_READ;
        else if (roll < 98) op = ilst_pkg::CMD_CLEAR;
        else                op = $urandom_range(1) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      // mostly legal positions, some anywhere in the field
      len = lists.fill_len;
      if ($urandom_range(4) == 0)          pos = ilst_pkg::POS_W'($urandom_range(31));
      else if (op == ilst_pkg::CMD_INSERT) pos = ilst_pkg::POS_W'($urandom_range(len));
      else if (len == 0)                   pos = '0;
      else                                 pos = ilst_pkg::POS_W'($urandom_range(len - 1));
      send_item(op, pos, pick_value());
    end
  endtask

  // Generous overall limit
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [ilst_pkg::VALUE_W-1:0] v;
    lists          = new();
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty list corner cases
    send_item(ilst_pkg::CMD_READ,   5'd0, 32'h0);
    send_item(ilst_pkg::CMD_ERASE,  5'd0, 32'h0);
    send_item(ilst_pkg::CMD_REMOVE, 5'd0, 32'h0);
    send_item(ilst_pkg::CMD_INSERT, 5'd1, 32'h1234_5678);

    // Fill to capacity with a mix of appends and inserts
    for (int i = 0; i < ilst_pkg::CAPACITY; i++) begin
      case (i)
        0: v = 32'h8000_0000;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'hFFFF_FFFF;
        3: v = 32'h0;
        default: v = $urandom;
      endcase
      if (i % 3 == 1)      send_item(ilst_pkg::CMD_INSERT, 5'd0, v);
      else if (i % 3 == 2) send_item(ilst_pkg::CMD_INSERT, ilst_pkg::POS_W'(i / 2), v);
      else                 send_item(ilst_pkg::CMD_APPEND, 5'd0, v);
    end

    // Full list and out-of-range cases
    send_item(ilst_pkg::CMD_APPEND, 5'd0,  32'hDEAD_BEEF);
    send_item(ilst_pkg::CMD_INSERT, 5'd16, 32'hDEAD_BEEF);
    send_item(ilst_pkg::CMD_INSERT, 5'd17, 32'hDEAD_BEEF);
    send_item(ilst_pkg::CMD_INSERT, 5'd31, 32'hDEAD_BEEF);
    send_item(ilst_pkg::CMD_READ,   5'd15, 32'h0);
    send_item(ilst_pkg::CMD_READ,   5'd16, 32'h0);
    send_item(ilst_pkg::CMD_ERASE,  5'd31, 32'h0);
    send_item(ilst_pkg::CMD_ERASE,  5'd0,  32'h0);
    send_item(ilst_pkg::CMD_ERASE,  5'd14, 32'h0);
    send_item(ilst_pkg::CMD_READ,   5'd0,  32'h0);
    send_item(OP_SPARE_LO, 5'd3, 32'hFFFF_FFFF);
    send_item(OP_SPARE_HI, 5'd31, 32'h8000_0000);
    send_item(ilst_pkg::CMD_CLEAR,  5'd0,  32'h0);
    send_item(ilst_pkg::CMD_REMOVE, 5'd0,  32'h0);

    // Random phases with different idling on each side
    run_random(PHASE_ITEMS);
    send_idle_pct = 83;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 0;
    sink_stall_pct = 83;
    run_random(PHASE_ITEMS);
    send_idle_pct  = 10;
    sink_stall_pct = 10;
    run_random(PHASE_ITEMS);

    // Drain outstanding results
    s_tvalid       <= 1'b0;
    sink_stall_pct = 0;
    while (lists.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (lists.errors == 0 && lists.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
